// ===== hdl/fwrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwrs_pkg: shared definitions for the Fenwick point-add / range-sum block
// Field widths, operation codes and default sizing.
// ----------------------------------------------------------------------------
package fwrs_pkg;

	localparam int IDX_W         = 11;   // index fields and size register
	localparam int ADD_W         = 32;   // signed addend
	localparam int SUM_W         = 64;   // store words and range sum
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage : fwrs_pkg
`default_nettype wire

// ===== hdl/fwrs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwrs_if: valid/ready channels of the Fenwick block
// Command channel, result channel and the size register write channel.
// ----------------------------------------------------------------------------
interface fwrs_cmd_if;
	import fwrs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [IDX_W-1:0]        index_a;
	logic [IDX_W-1:0]        index_b;
	logic signed [ADD_W-1:0] addend;

	modport source (output valid, op, index_a, index_b, addend, input ready);
	modport sink   (input valid, op, index_a, index_b, addend, output ready);
endinterface : fwrs_cmd_if

interface fwrs_rsp_if;
	import fwrs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] range_sum;
	logic                    index_error;

	modport source (output valid, range_sum, index_error, input ready);
	modport sink   (input valid, range_sum, index_error, output ready);
endinterface : fwrs_rsp_if

interface fwrs_cfg_if;
	import fwrs_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface : fwrs_cfg_if
`default_nettype wire

// ===== hdl/fenwick_point_add_range_sum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_point_add_range_sum: binary indexed tree, point add and range sum
// Store of DEPTH 64-bit words walked by one sequencer around a single adder.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  - writes size_in_use (positions covered, clamped to 1..DEPTH).
//          Always ready; write only while the block is idle.
//   cmd  - one beat per item. op add: adds addend at index_a, no result.
//          op query: one rsp beat with the sum of index_a..index_b.
//   rsp  - range_sum and index_error; a rejected query returns 0 and error.
// Sequencing:
//   cmd.ready is high only while the sequencer is idle. An add reads each
//   tree node it visits, then writes it back through the adder. A query
//   reads one node a cycle on the two prefix walks. A rejected add leaves
//   the sequencer idle; a rejected query goes straight to the finish state.
// Reset:
//   After arst_n the store is cleared one word a cycle, with cmd.ready low
//   until the last word is written; size_in_use returns to 1024.
// Stall:
//   The result sits in an output register; new items are taken while it
//   waits. A query finishing into a full output register waits there.
// ----------------------------------------------------------------------------
module fenwick_point_add_range_sum #(
	parameter int DEPTH = fwrs_pkg::DEPTH_DEFAULT
) (
	input  wire        clk,
	input  wire        arst_n,
	fwrs_cfg_if.sink   cfg,
	fwrs_cmd_if.sink   cmd,
	fwrs_rsp_if.source rsp
);
	import fwrs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// walk positions reach twice n, so at least one bit above the index width
	localparam int NW = (AW + 1 > IDX_W + 1) ? AW + 1 : IDX_W + 1;
	localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_Q_WALK,
		ST_Q_FIN
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        size_q;
	logic [AW-1:0]           clr_q;
	logic [NW-1:0]           pos_q;
	logic [NW-1:0]           a_m1_q;
	logic                    phase_q;
	logic                    bad_q;
	logic [SUM_W-1:0]        delta_q;
	logic [SUM_W-1:0]        acc_q;
	logic                    out_valid_q;
	logic [SUM_W-1:0]        out_sum_q;
	logic                    out_err_q;
	logic                    rd_v_s1;
	logic                    neg_s1;
	logic [SUM_W-1:0]        rdata_s1;
	logic [SUM_W-1:0]        store_q [DEPTH];

	logic [NW-1:0]    size_n, n_eff, a_n, b_n;
	logic [NW-1:0]    low, pos_up, pos_dn, pos_m1;
	logic [AW-1:0]    walk_addr;
	logic             q_bad, add_ok;
	logic [SUM_W-1:0] op_a, op_b, sum;
	logic             inv;
	logic             fin_go;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [SUM_W-1:0] mem_wdata;

	always_comb begin
		size_n = NW'(size_q);
		if (size_n == '0)
			n_eff = NW'(1);
		else if (size_n > DEPTH_N)
			n_eff = DEPTH_N;
		else
			n_eff = size_n;
	end

	assign a_n    = NW'(cmd.index_a);
	assign b_n    = NW'(cmd.index_b);
	assign q_bad  = (a_n == '0) || (b_n > n_eff) || (a_n > b_n);
	assign add_ok = (a_n != '0) && (a_n <= n_eff);

	// lowest set bit: up-walk adds it, down-walk clears it
	assign low       = pos_q & (~pos_q + NW'(1));
	assign pos_up    = pos_q + low;
	assign pos_dn    = pos_q & ~low;
	assign pos_m1    = pos_q - NW'(1);
	assign walk_addr = pos_m1[AW-1:0];

	// shared adder: store word + addend, or accumulator +/- store word
	assign inv  = rd_v_s1 & neg_s1;
	assign op_a = rd_v_s1 ? acc_q : delta_q;
	assign op_b = rdata_s1 ^ {SUM_W{inv}};
	assign sum  = op_a + op_b + SUM_W'(inv);

	// finished query moves into the output register once it is free
	assign fin_go = (state_q == ST_Q_FIN) && (!out_valid_q || rsp.ready);

	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_ADD_WR);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : walk_addr;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : sum;

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_waddr] <= mem_wdata;
		rdata_s1 <= store_q[walk_addr];
	end

	assign cfg.ready       = 1'b1;
	assign cmd.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.range_sum   = out_sum_q;
	assign rsp.index_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			size_q      <= SIZE_RESET;
			clr_q       <= '0;
			pos_q       <= '0;
			a_m1_q      <= '0;
			phase_q     <= 1'b0;
			bad_q       <= 1'b0;
			delta_q     <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_sum_q   <= '0;
			out_err_q   <= 1'b0;
			rd_v_s1     <= 1'b0;
			neg_s1      <= 1'b0;
		end else begin
			if (cfg.valid)
				size_q <= cfg.data;
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			if (rd_v_s1)
				acc_q <= sum;

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_A)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.valid) begin
						delta_q <= {{(SUM_W-ADD_W){cmd.addend[ADD_W-1]}}, cmd.addend};
						a_m1_q  <= a_n - NW'(1);
						if (cmd.op == OP_ADD) begin
							pos_q <= a_n;
							if (add_ok)
								state_q <= ST_ADD_RD;
						end else begin
							acc_q   <= '0;
							phase_q <= 1'b0;
							pos_q   <= b_n;
							bad_q   <= q_bad;
							if (q_bad)
								state_q <= ST_Q_FIN;
							else
								state_q <= ST_Q_WALK;
						end
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: begin
					pos_q <= pos_up;
					state_q <= (pos_up > n_eff) ? ST_IDLE : ST_ADD_RD;
				end
				ST_Q_WALK: begin
					if (pos_q == '0) begin
						rd_v_s1 <= 1'b0;
						if (!phase_q) begin
							// right prefix done, now subtract prefix(left-1)
							phase_q <= 1'b1;
							pos_q   <= a_m1_q;
						end else begin
							state_q <= ST_Q_FIN;
						end
					end else begin
						rd_v_s1 <= 1'b1;
						neg_s1  <= phase_q;
						pos_q   <= pos_dn;
					end
				end
				ST_Q_FIN: begin
					if (fin_go) begin
						out_sum_q <= bad_q ? '0 : acc_q;
						out_err_q <= bad_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.index_error |-> rsp.range_sum == '0)
		else $error("rejected query carries a non-zero sum");

	a_add_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_RD) |-> (pos_q != '0) && (pos_q <= n_eff))
		else $error("add walk outside the tree");

	a_read_follows_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q) == ST_Q_WALK)
		else $error("accumulate without a query read");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && (cmd.op == OP_QUERY) |=> !cmd.ready)
		else $error("ready after a query beat");

endmodule : fenwick_point_add_range_sum
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Fenwick point-add / range-sum block
// Drives add and query beats with random gaps and stalls, keeps a shadow
// binary indexed tree updated at each accepted beat, and checks every range
// sum against it. Covers the edge cases first, then random traffic over a
// series of size_in_use settings, including clamped and extreme ones.
// ----------------------------------------------------------------------------
module tb_top;
	import fwrs_pkg::*;

	localparam int          DEPTH       = DEPTH_DEFAULT;
	localparam int          SETTLE      = 64;        // covers the longest add walk
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] index_a;
		logic [IDX_W-1:0] index_b;
		logic [ADD_W-1:0] addend;
	} cmd_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] range_sum;
		logic                    index_error;
	} sum_expect_t;

	logic clk;
	logic arst_n;

	fwrs_cfg_if cfg_ch ();
	fwrs_cmd_if cmd_ch ();
	fwrs_rsp_if rsp_ch ();

	fenwick_point_add_range_sum #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the tree and the size register
	logic [SUM_W-1:0] shadow_tree [DEPTH];
	logic [IDX_W-1:0] size_reg;

	cmd_item_t   cmd_backlog [$];
	sum_expect_t expected_sums [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned adds_applied;
	int unsigned adds_ignored;
	int unsigned queries_ok;
	int unsigned queries_rejected;
	int unsigned size_writes;

	logic [IDX_W-1:0] size_plan [11] = '{11'd7, 11'd0, 11'd1, 11'd2, 11'd2047, 11'd100,
		11'd1025, 11'd37, 11'd512, 11'd1024, 11'd1000};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// size clamped to 1..DEPTH
	function automatic int unsigned active_positions();
		int unsigned n;
		n = 32'(size_reg);
		if (n < 1) n = 1;
		if (n > DEPTH) n = DEPTH;
		return n;
	endfunction

	function automatic logic [SUM_W-1:0] prefix_total(int unsigned pos);
		logic [SUM_W-1:0] acc;
		acc = '0;
		while (pos > 0) begin
			if (pos <= DEPTH) acc = acc + shadow_tree[pos-1];
			pos = pos - (pos & (~pos + 1));
		end
		return acc;
	endfunction

	task automatic apply_item(input cmd_item_t it);
		int unsigned n;
		int unsigned pos;
		int unsigned a;
		int unsigned b;
		logic [SUM_W-1:0] delta;
		sum_expect_t want;
		n = active_positions();
		a = 32'(it.index_a);
		b = 32'(it.index_b);
		if (it.op == OP_ADD) begin
			if (a >= 1 && a <= n) begin
				delta = {{(SUM_W-ADD_W){it.addend[ADD_W-1]}}, it.addend};
				pos = a;
				while (pos <= n) begin
					shadow_tree[pos-1] = shadow_tree[pos-1] + delta;
					pos = pos + (pos & (~pos + 1));
				end
				adds_applied++;
			end else begin
				adds_ignored++;
			end
		end else begin
			if (a < 1 || b > n || a > b) begin
				want.range_sum   = '0;
				want.index_error = 1'b1;
				queries_rejected++;
			end else begin
				want.range_sum   = prefix_total(b) - prefix_total(a - 1);
				want.index_error = 1'b0;
				queries_ok++;
			end
			expected_sums.insert(expected_sums.size(), want);
		end
	endtask

	// command driver: the beat on the bus is folded into the shadow tree when taken
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		cmd_item_t nxt;
		cmd_item_t cur;
		if (!arst_n) begin
			cmd_ch.valid   <= 1'b0;
			cmd_ch.op      <= OP_ADD;
			cmd_ch.index_a <= '0;
			cmd_ch.index_b <= '0;
			cmd_ch.addend  <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				cur.op      = cmd_ch.op;
				cur.index_a = cmd_ch.index_a;
				cur.index_b = cmd_ch.index_b;
				cur.addend  = cmd_ch.addend;
				apply_item(cur);
			end
			if (cmd_ch.valid && !cmd_ch.ready) begin
				// beat still waiting, hold it
			end else if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = cmd_backlog.pop_front();
				cmd_ch.valid   <= 1'b1;
				cmd_ch.op      <= nxt.op;
				cmd_ch.index_a <= nxt.index_a;
				cmd_ch.index_b <= nxt.index_b;
				cmd_ch.addend  <= nxt.addend;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		sum_expect_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_sums.size() == 0) begin
					$error("unexpected result beat: range_sum %0d, index_error %0b",
						rsp_ch.range_sum, rsp_ch.index_error);
					fail_count++;
				end else begin
					want = expected_sums.pop_front();
					if (rsp_ch.range_sum !== want.range_sum) begin
						$error("range_sum mismatch: expected %0d, actual %0d",
							want.range_sum, rsp_ch.range_sum);
						fail_count++;
					end
					if (rsp_ch.index_error !== want.index_error) begin
						$error("index_error mismatch: expected %0b, actual %0b",
							want.index_error, rsp_ch.index_error);
						fail_count++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_item(input logic op, input int unsigned a, input int unsigned b,
			input logic [ADD_W-1:0] addend);
		cmd_item_t it;
		it.op      = op;
		it.index_a = a[IDX_W-1:0];
		it.index_b = b[IDX_W-1:0];
		it.addend  = addend;
		cmd_backlog.insert(cmd_backlog.size(), it);
	endtask

	// mostly in-range beats; one in ten is left with raw random indices
	task automatic queue_random(input int unsigned want);
		int unsigned n;
		int unsigned done;
		int unsigned lo;
		cmd_item_t it;
		n = active_positions();
		done = 0;
		while (done < want) begin
			it.op      = ($urandom_range(99) < 55) ? OP_ADD : OP_QUERY;
			it.index_a = IDX_W'($urandom);
			it.index_b = IDX_W'($urandom);
			it.addend  = $urandom;
			if ($urandom_range(3) == 0)
				it.addend = $urandom_range(200) - 100;
			if ($urandom_range(9) != 0) begin
				lo = $urandom_range(n, 1);
				it.index_a = IDX_W'(lo);
				it.index_b = IDX_W'($urandom_range(n, lo));
			end
			cmd_backlog.insert(cmd_backlog.size(), it);
			if (it.op == OP_QUERY || (it.index_a >= 1 && it.index_a <= n))
				done++;
		end
	endtask

	task automatic drain();
		while (cmd_backlog.size() > 0 || cmd_ch.valid || expected_sums.size() > 0)
			@(posedge clk);
	endtask

	// an add leaves no result, so give the last walk time to finish
	task automatic wait_idle();
		drain();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [IDX_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		size_reg = value;
		size_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_idling(input int phase);
		if (phase < 4) begin
			send_idle_pct  = 25;
			recv_stall_pct = 54;
		end else if (phase < 8) begin
			send_idle_pct  = 54;
			recv_stall_pct = 25;
		end else begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
	endtask

	initial begin
		cmd_ch.valid   = 1'b0;
		cmd_ch.op      = OP_ADD;
		cmd_ch.index_a = '0;
		cmd_ch.index_b = '0;
		cmd_ch.addend  = '0;
		rsp_ch.ready   = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.data    = '0;
		arst_n         = 1'b0;
		cycle_count    = 0;
		fail_count     = 0;
		adds_applied   = 0;
		adds_ignored   = 0;
		queries_ok     = 0;
		queries_rejected = 0;
		size_writes    = 0;
		size_reg       = SIZE_RESET;
		for (int i = 0; i < DEPTH; i++) shadow_tree[i] = '0;
		set_idling(0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// edge cases at the reset size
		queue_item(OP_ADD,      1,    0, 32'h7FFF_FFFF);
		queue_item(OP_ADD,   1024,    0, 32'h8000_0000);
		queue_item(OP_ADD,      0,    0, 32'd5);          // position zero, ignored
		queue_item(OP_ADD,   1025,    0, 32'd7);          // past the end, ignored
		queue_item(OP_ADD,   2047, 2047, 32'hFFFF_FFFF);  // all index bits set, ignored
		queue_item(OP_ADD,    512, 2047, 32'hFFFF_FFFF);
		queue_item(OP_ADD,      3,    0, 32'h5555_5555);
		queue_item(OP_ADD,    768,    0, 32'hAAAA_AAAA);
		queue_item(OP_ADD,   1023,    0, 32'h0000_0000);
		queue_item(OP_QUERY,    1, 1024, 32'h0);
		queue_item(OP_QUERY,    1,    1, 32'h0);
		queue_item(OP_QUERY, 1024, 1024, 32'h0);
		queue_item(OP_QUERY,  512,  512, 32'h0);
		queue_item(OP_QUERY,    2, 1023, 32'h0);
		queue_item(OP_QUERY, 1023, 1024, 32'h0);
		queue_item(OP_QUERY,    0,    5, 32'h0);          // left bound zero
		queue_item(OP_QUERY,    0,    0, 32'h0);
		queue_item(OP_QUERY,    5, 1025, 32'h0);          // right bound past the end
		queue_item(OP_QUERY,   10,    9, 32'h0);          // left above right
		queue_item(OP_QUERY, 2047, 2047, 32'h0);
		queue_item(OP_QUERY,    1, 2047, 32'h0);
		queue_item(OP_QUERY,    3,  768, 32'hFFFF_FFFF);  // addend ignored on a query
		queue_item(OP_ADD,      1,    0, 32'h7FFF_FFFF);
		queue_item(OP_QUERY,    1,    3, 32'h0);
		queue_random(150);
		wait_idle();

		// size changes keep the store, so later phases also see stale entries
		for (int p = 1; p <= 11; p++) begin
			set_idling(p);
			write_size(size_plan[p-1]);
			if (p == 6) begin
				queue_random(70);
				drain();                 // hold the sender until all sums are back
				queue_random(70);
			end else begin
				queue_random(140);
			end
			wait_idle();
		end

		if (expected_sums.size() != 0) begin
			$error("%0d range sums never arrived", expected_sums.size());
			fail_count++;
		end
		$display("Covered %0d adds (%0d out of range ignored) and %0d queries (%0d rejected)",
			adds_applied + adds_ignored, adds_ignored, queries_ok + queries_rejected,
			queries_rejected);
		$display("across %0d size writes, with clamped sizes and the 1 and 1024 extremes",
			size_writes);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule : tb_top

// ===== fenwick_point_add_range_sum.f =====
hdl/fwrs_pkg.sv
hdl/fwrs_if.sv
hdl/fenwick_point_add_range_sum.sv
bench/tb_top.sv
